@@ design/rpn_pkg.sv @@
// Shared types and constants for the RPN stack calculator.
`timescale 1ns / 1ps
package rpn_pkg;

   // stack sizing
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

   // divider sizing: Q16.16 dividend scaled by 2^16, 32-bit divisor
   localparam int DVD_W     = 48;
   localparam int DVS_W     = 32;
   localparam int DIV_STEPS = DVD_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   // command codes
   localparam logic [3:0] KIND_PUSH  = 4'd0;
   localparam logic [3:0] KIND_ADD   = 4'd1;
   localparam logic [3:0] KIND_SUB   = 4'd2;
   localparam logic [3:0] KIND_MUL   = 4'd3;
   localparam logic [3:0] KIND_DIV   = 4'd4;
   localparam logic [3:0] KIND_MOD   = 4'd5;
   localparam logic [3:0] KIND_TOP2  = 4'd6;
   localparam logic [3:0] KIND_LIST  = 4'd7;
   localparam logic [3:0] KIND_DUP   = 4'd8;
   localparam logic [3:0] KIND_SWAP  = 4'd9;
   localparam logic [3:0] KIND_CLEAR = 4'd10;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_ZDIV  = 3'd3;
   localparam logic [2:0] ST_FEW   = 3'd4;
   localparam logic [2:0] ST_EMPTY = 3'd5;

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [31:0] number;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
      logic [5:0]         element_index;
      logic [6:0]         depth_now;
      logic               last;
   } rsp_type;

endpackage

@@ design/rpn_stack_ram.sv @@
// Simple dual-port synchronous RAM holding the stack entries.
`timescale 1ns / 1ps
module rpn_stack_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ design/rpn_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rpn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpn_pkg::DVD_W-1:0]     dividend,
   input  logic [rpn_pkg::DVS_W-1:0]     divisor,
   output logic                          done,
   output logic [rpn_pkg::DVD_W-1:0]     quotient,
   output logic [rpn_pkg::DVS_W-1:0]     remainder
);
   import rpn_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    shifted;
   logic [DVS_W+1:0]  diff;
   logic              ge;

   // one shift-subtract step
   always_comb begin
      shifted = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      ge      = ~diff[DVS_W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W:0] : shifted;
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DVS_W-1:0];

endmodule

@@ design/rpn_stack_calculator_unit.sv @@
// Div and mod wait on the 48-step divider, mul takes an extra saturation step, and a list
// reads the stack and emits one beat per entry.
// Throughput: one command at a time; the next is accepted in the cycle after the last
// beat of the current one is loaded into the output register, later under stall.
// Reset: synchronous, active high; stack depth returns to zero, memory is untouched.
`timescale 1ns / 1ps
module rpn_stack_calculator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rpn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rpn_pkg::rsp_type rsp_data
);
   import rpn_pkg::*;

   typedef enum logic [19:0] {
      S_IDLE    = 20'h00001,
      S_DISP    = 20'h00002,
      S_POPB    = 20'h00004,
      S_GETB    = 20'h00008,
      S_POPA    = 20'h00010,
      S_GETA    = 20'h00020,
      S_CALC    = 20'h00040,
      S_MULSAT  = 20'h00080,
      S_DIVRUN  = 20'h00100,
      S_PUSHRES = 20'h00200,
      S_RDX     = 20'h00400,
      S_RDY     = 20'h00800,
      S_RDZ     = 20'h01000,
      S_WR1     = 20'h02000,
      S_WR2     = 20'h04000,
      S_LISTRD  = 20'h08000,
      S_LISTGET = 20'h10000,
      S_TOPRD   = 20'h20000,
      S_TOPGET  = 20'h40000,
      S_EMIT    = 20'h80000
   } state_type;

   // Q16.16 to integer, truncated toward zero
   function automatic logic signed [16:0] q_to_int(input logic signed [31:0] v);
      logic signed [16:0] t;
      t = 17'(v >>> 16);
      if (v[31] && (v[15:0] != 16'd0)) begin
         t = t + 17'sd1;
      end
      return t;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [15:0] mag16(input logic signed [16:0] v);
      return v[16] ? 16'(-v) : 16'(v);
   endfunction

   state_type          state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [3:0]         kind_ff, kind_in;
   logic signed [31:0] num_ff, num_in;
   logic [2:0]         st_ff, st_in;
   logic               under_ff, under_in;
   logic               have_ff, have_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic signed [31:0] res_ff, res_in;
   logic signed [31:0] first_ff, first_in;
   logic signed [31:0] second_ff, second_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic               last_ff, last_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [31:0]        wr_data, rd_data;
   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_dvd, div_quo;
   logic [DVS_W-1:0]   div_dvs, div_rem;

   logic               out_free;
   logic [ADDR_W-1:0]  top_addr, sec_addr, end_addr;
   logic signed [32:0] sum33;
   logic signed [47:0] mq;
   logic signed [16:0] a_int;
   logic [15:0]        rmod;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign top_addr = ADDR_W'(depth_ff - 1'b1);
   assign sec_addr = ADDR_W'(depth_ff - 2'd2);
   assign end_addr = ADDR_W'(depth_ff);
   assign a_int    = q_to_int(a_ff);
   assign rmod     = div_rem[15:0];

   // add/sub and the fixed-point product shift
   always_comb begin
      if (kind_ff == KIND_SUB) begin
         sum33 = 33'(a_ff) - 33'(b_ff);
      end else begin
         sum33 = 33'(a_ff) + 33'(b_ff);
      end
      mq = 48'(prod_ff >>> 16);
      if (prod_ff[63] && (prod_ff[15:0] != 16'd0)) begin
         mq = mq + 48'sd1;
      end
   end

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      kind_in      = kind_ff;
      num_in       = num_ff;
      st_in        = st_ff;
      under_in     = under_ff;
      have_in      = have_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = end_addr;
      wr_data      = res_ff;
      rd_en        = 1'b0;
      rd_addr      = top_addr;
      div_start    = 1'b0;
      div_dvd      = {mag32(a_ff), 16'd0};
      div_dvs      = mag32(b_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.kind;
               num_in    = req_data.number;
               st_in     = ST_OK;
               under_in  = 1'b0;
               second_in = '0;
               idx_in    = '0;
               last_in   = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_TOPRD;
            case (kind_ff)
               KIND_PUSH: begin
                  if (depth_ff < DEPTH_W'(STACK_DEPTH)) begin
                     res_in   = num_ff;
                     state_in = S_PUSHRES;
                  end else begin
                     st_in = ST_FULL;
                  end
               end
               KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD: begin
                  state_in = S_POPB;
               end
               KIND_TOP2, KIND_SWAP: begin
                  if (depth_ff == '0) st_in = ST_EMPTY;
                  else if (depth_ff == DEPTH_W'(1)) st_in = ST_FEW;
                  else state_in = S_RDX;
               end
               KIND_DUP: begin
                  if (depth_ff == '0) st_in = ST_EMPTY;
                  else if (depth_ff == DEPTH_W'(1)) st_in = ST_FEW;
                  else if (depth_ff > DEPTH_W'(STACK_DEPTH - 2)) st_in = ST_FULL;
                  else state_in = S_RDX;
               end
               KIND_LIST: begin
                  if (depth_ff == '0) begin
                     st_in    = ST_EMPTY;
                     first_in = '0;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_LISTRD;
                  end
               end
               KIND_CLEAR: begin
                  if (depth_ff == '0) st_in = ST_EMPTY;
                  else depth_in = '0;
               end
               default: begin
                  state_in = S_TOPRD;
               end
            endcase
         end
         // pop the right operand
         S_POPB: begin
            if (depth_ff != '0) begin
               rd_en    = 1'b1;
               depth_in = depth_ff - 1'b1;
               have_in  = 1'b1;
            end else begin
               under_in = 1'b1;
               have_in  = 1'b0;
            end
            state_in = S_GETB;
         end
         S_GETB: begin
            b_in     = have_ff ? $signed(rd_data) : 32'sd0;
            state_in = S_POPA;
            if ((kind_ff == KIND_DIV) && (b_in == 32'sd0)) begin
               st_in    = ST_ZDIV;
               state_in = S_TOPRD;
            end
            if ((kind_ff == KIND_MOD) && (q_to_int(b_in) == 17'sd0)) begin
               st_in    = ST_ZDIV;
               state_in = S_TOPRD;
            end
         end
         // pop the left operand
         S_POPA: begin
            if (depth_ff != '0) begin
               rd_en    = 1'b1;
               depth_in = depth_ff - 1'b1;
               have_in  = 1'b1;
            end else begin
               under_in = 1'b1;
               have_in  = 1'b0;
            end
            state_in = S_GETA;
         end
         S_GETA: begin
            a_in     = have_ff ? $signed(rd_data) : 32'sd0;
            state_in = S_CALC;
         end
         S_CALC: begin
            case (kind_ff)
               KIND_MUL: begin
                  prod_in  = a_ff * b_ff;
                  state_in = S_MULSAT;
               end
               KIND_DIV: begin
                  div_start = 1'b1;
                  state_in  = S_DIVRUN;
               end
               KIND_MOD: begin
                  div_start = 1'b1;
                  div_dvd   = DVD_W'(mag16(a_int));
                  div_dvs   = DVS_W'(mag16(q_to_int(b_ff)));
                  state_in  = S_DIVRUN;
               end
               default: begin
                  if (sum33[32] != sum33[31]) begin
                     res_in = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                  end else begin
                     res_in = sum33[31:0];
                  end
                  state_in = S_PUSHRES;
               end
            endcase
         end
         S_MULSAT: begin
            if (mq > 48'sh0000_7FFF_FFFF) res_in = 32'sh7FFF_FFFF;
            else if (mq < -48'sh0000_8000_0000) res_in = 32'sh8000_0000;
            else res_in = mq[31:0];
            state_in = S_PUSHRES;
         end
         S_DIVRUN: begin
            if (div_done) begin
               if (kind_ff == KIND_MOD) begin
                  res_in = a_ff[31] ? -$signed({rmod, 16'd0}) : $signed({rmod, 16'd0});
               end else if (a_ff[31] ^ b_ff[31]) begin
                  if (div_quo > 48'h0000_8000_0000) res_in = 32'sh8000_0000;
                  else res_in = -$signed(div_quo[31:0]);
               end else begin
                  if (div_quo > 48'h0000_7FFF_FFFF) res_in = 32'sh7FFF_FFFF;
                  else res_in = $signed(div_quo[31:0]);
               end
               state_in = S_PUSHRES;
            end
         end
         S_PUSHRES: begin
            wr_en    = 1'b1;
            depth_in = depth_ff + 1'b1;
            if (under_ff) st_in = ST_UNDER;
            state_in = S_TOPRD;
         end
         // read top and second for top two, dup and swap
         S_RDX: begin
            rd_en    = 1'b1;
            state_in = S_RDY;
         end
         S_RDY: begin
            a_in     = $signed(rd_data);
            rd_en    = 1'b1;
            rd_addr  = sec_addr;
            state_in = S_RDZ;
         end
         S_RDZ: begin
            b_in = $signed(rd_data);
            if (kind_ff == KIND_TOP2) begin
               first_in  = a_ff;
               second_in = b_in;
               state_in  = S_EMIT;
            end else begin
               state_in = S_WR1;
            end
         end
         S_WR1: begin
            wr_en    = 1'b1;
            wr_data  = b_ff;
            wr_addr  = (kind_ff == KIND_DUP) ? end_addr : top_addr;
            state_in = S_WR2;
         end
         S_WR2: begin
            wr_en   = 1'b1;
            wr_data = a_ff;
            if (kind_ff == KIND_DUP) begin
               wr_addr  = ADDR_W'(depth_ff + 1'b1);
               depth_in = depth_ff + 2'd2;
            end else begin
               wr_addr = sec_addr;
            end
            state_in = S_TOPRD;
         end
         S_LISTRD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_LISTGET;
         end
         S_LISTGET: begin
            first_in = $signed(rd_data);
            last_in  = (DEPTH_W'(idx_ff) + 1'b1) == depth_ff;
            state_in = S_EMIT;
         end
         S_TOPRD: begin
            rd_en    = (depth_ff != '0);
            state_in = S_TOPGET;
         end
         S_TOPGET: begin
            first_in = (depth_ff != '0) ? $signed(rd_data) : 32'sd0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = st_ff;
               rsp_in.first_value    = first_ff;
               rsp_in.second_value   = second_ff;
               rsp_in.element_index  = 6'(idx_ff);
               rsp_in.depth_now      = 7'(depth_ff);
               rsp_in.last           = last_ff;
               if ((kind_ff == KIND_LIST) && !last_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_LISTRD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      num_ff    <= num_in;
      st_ff     <= st_in;
      under_ff  <= under_in;
      have_ff   <= have_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      res_ff    <= res_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   rpn_stack_ram #(
      .DATA_W (32),
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpn_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/rpn_checker.sv @@
// Port-level checks for the RPN stack calculator, bound to the top level.
`timescale 1ns / 1ps
module rpn_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input rpn_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rpn_pkg::rsp_type rsp_data
);
   import rpn_pkg::*;

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // only list beats may be non-final, and those are ok
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.status == ST_OK)
      else $error("non-final beat with bad status");

   // empty status means nothing on the stack
   a_empty_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.depth_now == 7'd0)
      else $error("empty status with entries on stack");

   // too-few status means exactly one entry
   a_few_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FEW |-> rsp_data.depth_now == 7'd1)
      else $error("too-few status with wrong depth");

   // an error beat, such as zero-divisor, never carries a second value
   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.second_value == 32'sd0)
      else $error("second value set on error beat");

endmodule

bind rpn_stack_calculator_unit rpn_checker u_rpn_checker (.*);
